[rtl/text_to_lcd_glyph_stream_macros.svh]
// assertion macros used by the glyph stream emitter
`ifndef TEXT_TO_LCD_GLYPH_STREAM_MACROS_SVH
`define TEXT_TO_LCD_GLYPH_STREAM_MACROS_SVH

// same-cycle implication
`define TLG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tlg_pkg.sv]
// package: types and constants of the text to lcd glyph stream
`timescale 1ns / 1ps

package tlg_pkg;

	localparam int SCREEN_WIDTH_DEF  = 176;
	localparam int SCREEN_HEIGHT_DEF = 220;
	localparam int GLYPH_COUNT_DEF   = 37;

	// items per drawn character: six register writes, one command, 16 lines
	localparam int ITEMS_PER_CHAR = 23;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_FIRST   = 8'd32;
	localparam logic [7:0] CODE_LAST    = 8'd90;

	typedef enum logic [1:0] {
		KIND_REG  = 2'd0,
		KIND_CMD  = 2'd1,
		KIND_LINE = 2'd2
	} kind_t;

	localparam logic [7:0] REG_WIN_X_END   = 8'h36;
	localparam logic [7:0] REG_WIN_X_START = 8'h37;
	localparam logic [7:0] REG_WIN_Y_END   = 8'h38;
	localparam logic [7:0] REG_WIN_Y_START = 8'h39;
	localparam logic [7:0] REG_GRAM_X      = 8'h20;
	localparam logic [7:0] REG_GRAM_Y      = 8'h21;
	localparam logic [7:0] REG_GRAM_WRITE  = 8'h22;

	typedef enum logic [1:0] {
		CFG_ORIGIN_X   = 2'd0,
		CFG_ORIGIN_Y   = 2'd1,
		CFG_FORE_COLOR = 2'd2,
		CFG_BACK_COLOR = 2'd3
	} cfg_index_t;

	// one drawn character waiting for or under emission
	typedef struct packed {
		logic [7:0]  x;
		logic [15:0] y;
		logic [5:0]  glyph;
		logic        blank;
	} job_t;

	// font row request towards the glyph rom
	typedef struct packed {
		logic       en;
		logic [5:0] glyph;
		logic [2:0] row;
	} font_req_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] idx;
	} glyph_map_t;

	// space -> 0, digits -> 1..10, letters -> 11..36
	function automatic glyph_map_t glyph_of(input logic [7:0] code);
		glyph_map_t g;
		g = '0;
		if (code == 8'd32) begin
			g.hit = 1'b1;
			g.idx = 6'd0;
		end else if (code >= 8'd48 && code <= 8'd57) begin
			g.hit = 1'b1;
			g.idx = 6'(code - 8'd47);
		end else if (code >= 8'd65 && code <= 8'd90) begin
			g.hit = 1'b1;
			g.idx = 6'(code - 8'd54);
		end
		return g;
	endfunction

endpackage

[rtl/text_to_lcd_glyph_stream.sv]
// top level of the text to lcd glyph stream
`timescale 1ns / 1ps

// Character generator for a window/GRAM driven lcd panel with an 8x8 font
// shown at twice its size. Each text item that draws a glyph yields 23
// output items: six window and GRAM address register writes, one GRAM write
// command and 16 line masks (tuser says which kind). A drawn character goes
// out one item per cycle while the receiver is ready, and back-to-back
// characters stream with no gap; the first character after idle passes the
// slot, the active job register, the font rom read and the output register.
// Newline, characters outside the printable range and characters while
// stopped are consumed and yield nothing. One drawn character can wait in a
// slot while the previous one is being sent, so the input stalls only when
// that slot is full. The cursor, its origin and the stopped flag sit in
// registers; the glyph rows come from a synchronous font rom read in the stage
// ahead of the output register. Colour registers are accepted on the
// configuration channel and are consumed by the pixel serializer downstream;
// the user must write configuration while the block is idle; it is not enforced.
module text_to_lcd_glyph_stream #(
	parameter int SCREEN_WIDTH  = tlg_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tlg_pkg::SCREEN_HEIGHT_DEF,
	parameter int GLYPH_COUNT   = tlg_pkg::GLYPH_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // string_end
	// output items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] reg_addr, [23:8] reg_value, [39:24] line_mask
	output logic [1:0]  m_tuser,   // [1:0] item_kind
	output logic        m_tlast,   // run_last
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tlg_pkg::job_t      job;
	logic               job_valid, job_take;
	tlg_pkg::font_req_t font_req;
	logic [7:0]         font_row;
	logic [7:0]         out_addr;
	logic [15:0]        out_value, out_mask;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// cursor tracking and the pending drawn character
	tlg_cursor #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.GLYPH_COUNT   (GLYPH_COUNT)
	) u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.char_code  (s_tdata),
		.string_end (s_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.job_valid  (job_valid),
		.job        (job),
		.job_take   (job_take)
	);

	// glyph rows, registered read
	tlg_font_rom u_font (
		.clk      (clk),
		.req      (font_req),
		.row_data (font_row)
	);

	// sequence of 23 items per character and the output register
	tlg_emitter u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.font_req  (font_req),
		.font_row  (font_row),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_addr  (out_addr),
		.out_value (out_value),
		.out_mask  (out_mask),
		.out_last  (m_tlast)
	);

	assign m_tdata = {out_mask, out_value, out_addr};

endmodule

[rtl/tlg_font_rom.sv]
// synchronous 8x8 font rom, one row per read
`timescale 1ns / 1ps

module tlg_font_rom (
	input  logic              clk,
	input  tlg_pkg::font_req_t req,
	output logic [7:0]        row_data
);

	localparam int FONT_ROWS = 37;

	// row 0 in the top byte
	localparam logic [63:0] FONT [FONT_ROWS] = '{
		64'h0000000000000000, 64'h3C666E7666663C00, 64'h1838181818183C00,
		64'h3C66061C30607E00, 64'h3C66061C06663C00, 64'h0C1C3C6C7E0C0C00,
		64'h7E607C0606663C00, 64'h1C30607C66663C00, 64'h7E66060C18181800,
		64'h3C66663C66663C00, 64'h3C66663E060C3800, 64'h183C66667E666600,
		64'h7C66667C66667C00, 64'h3C66606060663C00, 64'h786C6666666C7800,
		64'h7E60607C60607E00, 64'h7E60607C60606000, 64'h3C66606E66663C00,
		64'h6666667E66666600, 64'h3C18181818183C00, 64'h1E0C0C0C0C6C3800,
		64'h666C7870786C6600, 64'h6060606060607E00, 64'h63777F6B63636300,
		64'h66767E7E6E666600, 64'h3C66666666663C00, 64'h7C66667C60606000,
		64'h3C6666666E6C3600, 64'h7C66667C786C6600, 64'h3C6630180C663C00,
		64'h7E18181818181800, 64'h6666666666663C00, 64'h66666666663C1800,
		64'h6363636B7F776300, 64'h66663C183C666600, 64'h66663C1818181800,
		64'h7E060C1830607E00
	};

	logic [7:0] row_q;
	logic [63:0] glyph_bits;

	always_comb begin
		glyph_bits = '0;
		if (req.glyph < 6'(FONT_ROWS)) begin
			glyph_bits = FONT[req.glyph];
		end
	end

	always_ff @(posedge clk) begin
		if (req.en) begin
			row_q <= glyph_bits[6'd63 - {req.row, 3'b000} -: 8];
		end
	end

	assign row_data = row_q;

endmodule

[rtl/tlg_cursor.sv]
// text cursor, origin registers and the one-deep pending character slot
`timescale 1ns / 1ps

module tlg_cursor #(
	parameter int SCREEN_WIDTH  = tlg_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tlg_pkg::SCREEN_HEIGHT_DEF,
	parameter int GLYPH_COUNT   = tlg_pkg::GLYPH_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    char_code,
	input  logic          string_end,
	input  logic          cfg_valid,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	output logic          job_valid,
	output tlg_pkg::job_t job,
	input  logic          job_take
);

	localparam logic [9:0]  W_LIM = 10'(SCREEN_WIDTH);
	localparam logic [16:0] H_LIM = 17'(SCREEN_HEIGHT);
	localparam logic [6:0]  G_LIM = 7'(GLYPH_COUNT);

	logic [7:0]    origin_x_q, origin_y_q, col_q;
	logic [15:0]   row_q;
	logic          stopped_q, pend_valid_q;
	tlg_pkg::job_t pend_q;

	logic               accept, drawable, do_draw;
	tlg_pkg::glyph_map_t gmap;
	logic [8:0]         col_adv;
	logic [7:0]         col_n;
	logic [15:0]        row_n;
	logic               stop_n;

	function automatic logic [15:0] row_down(input logic [15:0] r);
		return (r > 16'd65519) ? 16'hFFFF : r + 16'd16;
	endfunction

	assign in_ready = !pend_valid_q || job_take;
	assign accept   = in_valid && in_ready;
	assign gmap     = tlg_pkg::glyph_of(char_code);
	assign drawable = (char_code >= tlg_pkg::CODE_FIRST) && (char_code <= tlg_pkg::CODE_LAST);
	assign do_draw  = accept && !stopped_q && drawable && (char_code != tlg_pkg::CODE_NEWLINE);

	always_comb begin
		col_n   = col_q;
		row_n   = row_q;
		stop_n  = stopped_q;
		col_adv = {1'b0, col_q} + 9'd16;
		if (!stopped_q) begin
			if (char_code == tlg_pkg::CODE_NEWLINE) begin
				col_n = origin_x_q;
				row_n = row_down(row_q);
			end else begin
				if ({1'b0, col_adv} + 10'd16 > W_LIM) begin
					col_n = origin_x_q;
					row_n = row_down(row_q);
				end else begin
					col_n = col_adv[7:0];
				end
				if ({1'b0, row_n} + 17'd16 > H_LIM) begin
					stop_n = 1'b1;
				end
			end
		end
		if (string_end) begin
			col_n  = origin_x_q;
			row_n  = {8'd0, origin_y_q};
			stop_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			col_q        <= '0;
			row_q        <= '0;
			stopped_q    <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				col_q     <= col_n;
				row_q     <= row_n;
				stopped_q <= stop_n;
			end
			if (do_draw) begin
				pend_valid_q <= 1'b1;
			end else if (job_take) begin
				pend_valid_q <= 1'b0;
			end
			// colour registers belong to the pixel serializer downstream
			if (cfg_valid) begin
				case (cfg_index)
					tlg_pkg::CFG_ORIGIN_X: begin
						origin_x_q <= cfg_data[7:0];
						col_q      <= cfg_data[7:0];
					end
					tlg_pkg::CFG_ORIGIN_Y: begin
						origin_y_q <= cfg_data[7:0];
						row_q      <= {8'd0, cfg_data[7:0]};
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_draw) begin
			pend_q.x     <= col_q;
			pend_q.y     <= row_q;
			pend_q.glyph <= gmap.idx;
			pend_q.blank <= !gmap.hit || ({1'b0, gmap.idx} >= G_LIM);
		end
	end

	assign job_valid = pend_valid_q;
	assign job       = pend_q;

endmodule

[rtl/tlg_emitter.sv]
// item sequencer, font read stage and output register
`timescale 1ns / 1ps

`include "text_to_lcd_glyph_stream_macros.svh"

module tlg_emitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  tlg_pkg::job_t      job,
	output logic               job_take,
	output tlg_pkg::font_req_t font_req,
	input  logic [7:0]         font_row,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_kind,
	output logic [7:0]         out_addr,
	output logic [15:0]        out_value,
	output logic [15:0]        out_mask,
	output logic               out_last
);

	localparam logic [4:0] CNT_LAST  = 5'(tlg_pkg::ITEMS_PER_CHAR - 1);
	localparam logic [4:0] CNT_LINE0 = 5'd7;

	typedef struct packed {
		tlg_pkg::kind_t kind;
		logic [7:0]     addr;
		logic [15:0]    value;
		logic           last;
		logic           blank;
	} desc_t;

	logic          busy_q;
	logic [4:0]    cnt_q;
	tlg_pkg::job_t act_q;
	logic          valid_s1;
	desc_t         desc_s1;
	desc_t         desc_n;
	logic          out_valid_q;
	logic          adv;
	logic [4:0]    line_idx;

	function automatic logic [15:0] double_bits(input logic [7:0] b);
		logic [15:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			m[2*i]   = b[i];
			m[2*i+1] = b[i];
		end
		return m;
	endfunction

	assign adv      = !out_valid_q || out_ready;
	assign job_take = adv && job_valid && (!busy_q || cnt_q == CNT_LAST);
	assign line_idx = cnt_q - CNT_LINE0;

	always_comb begin
		desc_n       = '0;
		desc_n.blank = act_q.blank;
		case (cnt_q)
			5'd0: begin
				desc_n.kind  = tlg_pkg::KIND_REG;
				desc_n.addr  = tlg_pkg::REG_WIN_X_END;
				desc_n.value = {8'd0, act_q.x} + 16'd15;
			end
			5'd1: begin
				desc_n.kind  = tlg_pkg::KIND_REG;
				desc_n.addr  = tlg_pkg::REG_WIN_X_START;
				desc_n.value = {8'd0, act_q.x};
			end
			5'd2: begin
				desc_n.kind  = tlg_pkg::KIND_REG;
				desc_n.addr  = tlg_pkg::REG_WIN_Y_END;
				desc_n.value = act_q.y + 16'd15;
			end
			5'd3: begin
				desc_n.kind  = tlg_pkg::KIND_REG;
				desc_n.addr  = tlg_pkg::REG_WIN_Y_START;
				desc_n.value = act_q.y;
			end
			5'd4: begin
				desc_n.kind  = tlg_pkg::KIND_REG;
				desc_n.addr  = tlg_pkg::REG_GRAM_X;
				desc_n.value = {8'd0, act_q.x};
			end
			5'd5: begin
				desc_n.kind  = tlg_pkg::KIND_REG;
				desc_n.addr  = tlg_pkg::REG_GRAM_Y;
				desc_n.value = act_q.y;
			end
			5'd6: begin
				desc_n.kind = tlg_pkg::KIND_CMD;
				desc_n.addr = tlg_pkg::REG_GRAM_WRITE;
			end
			default: begin
				desc_n.kind = tlg_pkg::KIND_LINE;
				desc_n.last = (cnt_q == CNT_LAST);
			end
		endcase
	end

	// each font row goes out on two consecutive lines
	assign font_req.en    = adv;
	assign font_req.glyph = act_q.glyph;
	assign font_req.row   = line_idx[3:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= busy_q;
			out_valid_q <= valid_s1;
			if (job_take) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			act_q <= job;
		end
		if (adv) begin
			desc_s1   <= desc_n;
			out_kind  <= desc_s1.kind;
			out_addr  <= desc_s1.addr;
			out_value <= desc_s1.value;
			out_last  <= desc_s1.last;
			out_mask  <= (desc_s1.kind == tlg_pkg::KIND_LINE && !desc_s1.blank)
				? double_bits(font_row) : 16'd0;
		end
	end

	assign out_valid = out_valid_q;

	`TLG_ASSERT_SAME(a_take_needs_job, job_take, job_valid, "job taken from an empty slot")
	`TLG_ASSERT_SAME(a_cnt_bound, busy_q, cnt_q <= CNT_LAST, "item counter past last item")
	`TLG_ASSERT_NEXT(a_last_line, adv && busy_q && cnt_q == CNT_LAST, valid_s1 && desc_s1.last, "final line not marked")
	`TLG_ASSERT_SAME(a_last_is_line, out_valid_q && out_last, out_kind == tlg_pkg::KIND_LINE, "run end on a non-line item")

endmodule

[tb/tb.sv]
// testbench for the text to lcd glyph stream: directed and random text against a predictor
`timescale 1ns / 1ps

module tb;

	localparam int SCREEN_W    = tlg_pkg::SCREEN_WIDTH_DEF;
	localparam int SCREEN_H    = tlg_pkg::SCREEN_HEIGHT_DEF;
	localparam int GLYPHS      = tlg_pkg::GLYPH_COUNT_DEF;
	localparam int ROW_MAX     = 65535;
	localparam int CYCLE_LIMIT = 2000000;
	// cycles allowed after the last item for characters that yield nothing
	localparam int SETTLE      = 16;
	// text items sent in each random phase
	localparam int PHASE_CHARS = 85;

	// one output item as the panel side sees it
	typedef struct {
		tlg_pkg::kind_t kind;
		logic [7:0]     addr;
		logic [15:0]    value;
		logic [15:0]    mask;
		logic           last;
	} lcd_item_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	// items the block owes us, oldest first
	lcd_item_t   lcd_items_due[$];

	// predicted cursor state and origin
	int          org_x   = 0;
	int          org_y   = 0;
	int          cur_col = 0;
	int          cur_row = 0;
	bit          halted  = 1'b0;

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          sent_chars     = 0;
	int          fail_count     = 0;
	int          items_seen     = 0;
	int unsigned cycle_count    = 0;

	text_to_lcd_glyph_stream DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// receiver back-pressure, rate set per phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// 8x8 font, top row in the high byte
	function automatic logic [7:0] font_byte(input int g, input int r);
		logic [63:0] rows;
		case (g)
			1:       rows = 64'h3C666E7666663C00;
			2:       rows = 64'h1838181818183C00;
			3:       rows = 64'h3C66061C30607E00;
			4:       rows = 64'h3C66061C06663C00;
			5:       rows = 64'h0C1C3C6C7E0C0C00;
			6:       rows = 64'h7E607C0606663C00;
			7:       rows = 64'h1C30607C66663C00;
			8:       rows = 64'h7E66060C18181800;
			9:       rows = 64'h3C66663C66663C00;
			10:      rows = 64'h3C66663E060C3800;
			11:      rows = 64'h183C66667E666600;
			12:      rows = 64'h7C66667C66667C00;
			13:      rows = 64'h3C66606060663C00;
			14:      rows = 64'h786C6666666C7800;
			15:      rows = 64'h7E60607C60607E00;
			16:      rows = 64'h7E60607C60606000;
			17:      rows = 64'h3C66606E66663C00;
			18:      rows = 64'h6666667E66666600;
			19:      rows = 64'h3C18181818183C00;
			20:      rows = 64'h1E0C0C0C0C6C3800;
			21:      rows = 64'h666C7870786C6600;
			22:      rows = 64'h6060606060607E00;
			23:      rows = 64'h63777F6B63636300;
			24:      rows = 64'h66767E7E6E666600;
			25:      rows = 64'h3C66666666663C00;
			26:      rows = 64'h7C66667C60606000;
			27:      rows = 64'h3C6666666E6C3600;
			28:      rows = 64'h7C66667C786C6600;
			29:      rows = 64'h3C6630180C663C00;
			30:      rows = 64'h7E18181818181800;
			31:      rows = 64'h6666666666663C00;
			32:      rows = 64'h66666666663C1800;
			33:      rows = 64'h6363636B7F776300;
			34:      rows = 64'h66663C183C666600;
			35:      rows = 64'h66663C1818181800;
			36:      rows = 64'h7E060C1830607E00;
			default: rows = 64'h0;
		endcase
		return rows[63 - 8 * r -: 8];
	endfunction

	// font slot of a character, -1 when it is drawn blank
	function automatic int glyph_slot(input logic [7:0] code);
		int g;
		if (code == tlg_pkg::CODE_FIRST)
			g = 0;
		else if (code >= "0" && code <= "9")
			g = 1 + int'(code - "0");
		else if (code >= "A" && code <= "Z")
			g = 11 + int'(code - "A");
		else
			g = -1;
		if (g >= GLYPHS)
			g = -1;
		return g;
	endfunction

	// each font pixel becomes two screen pixels
	function automatic logic [15:0] stretch_row(input logic [7:0] b);
		logic [15:0] m;
		for (int i = 0; i < 8; i++)
			m[2 * i +: 2] = {2{b[i]}};
		return m;
	endfunction

	function automatic int row_down(input int r);
		return (r > ROW_MAX - 16) ? ROW_MAX : r + 16;
	endfunction

	function automatic void owe_item(input tlg_pkg::kind_t k, input logic [7:0] a,
			input logic [15:0] v, input logic [15:0] m, input logic l);
		lcd_item_t it;
		it.kind  = k;
		it.addr  = a;
		it.value = v;
		it.mask  = m;
		it.last  = l;
		lcd_items_due.push_back(it);
	endfunction

	// works out the items one accepted character causes and moves the cursor
	function automatic void predict_glyph_items(input logic [7:0] code, input logic fin);
		int          g;
		logic [15:0] x;
		logic [15:0] y;
		if (!halted) begin
			if (code == tlg_pkg::CODE_NEWLINE) begin
				cur_col = org_x;
				cur_row = row_down(cur_row);
			end else begin
				if (code >= tlg_pkg::CODE_FIRST && code <= tlg_pkg::CODE_LAST) begin
					x = 16'(cur_col);
					y = 16'(cur_row);
					g = glyph_slot(code);
					owe_item(tlg_pkg::KIND_REG, tlg_pkg::REG_WIN_X_END, x + 16'd15, '0, 1'b0);
					owe_item(tlg_pkg::KIND_REG, tlg_pkg::REG_WIN_X_START, x, '0, 1'b0);
					owe_item(tlg_pkg::KIND_REG, tlg_pkg::REG_WIN_Y_END, y + 16'd15, '0, 1'b0);
					owe_item(tlg_pkg::KIND_REG, tlg_pkg::REG_WIN_Y_START, y, '0, 1'b0);
					owe_item(tlg_pkg::KIND_REG, tlg_pkg::REG_GRAM_X, x, '0, 1'b0);
					owe_item(tlg_pkg::KIND_REG, tlg_pkg::REG_GRAM_Y, y, '0, 1'b0);
					owe_item(tlg_pkg::KIND_CMD, tlg_pkg::REG_GRAM_WRITE, '0, '0, 1'b0);
					for (int line = 0; line < 16; line++)
						owe_item(tlg_pkg::KIND_LINE, '0, '0,
							(g < 0) ? 16'h0 : stretch_row(font_byte(g, line / 2)),
							line == 15);
				end
				cur_col += 16;
				if (cur_col + 16 > SCREEN_W) begin
					cur_col = org_x;
					cur_row = row_down(cur_row);
				end
				cur_col &= 255;
				if (cur_row + 16 > SCREEN_H)
					halted = 1'b1;
			end
		end
		if (fin) begin
			cur_col = org_x;
			cur_row = org_y;
			halted  = 1'b0;
		end
	endfunction

	// output checker: every accepted item against the oldest one owed
	always @(posedge clk) begin
		lcd_item_t got;
		lcd_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind  = tlg_pkg::kind_t'(m_tuser);
			got.addr  = m_tdata[7:0];
			got.value = m_tdata[23:8];
			got.mask  = m_tdata[39:24];
			got.last  = m_tlast;
			if (lcd_items_due.size() == 0) begin
				if (fail_count < 10)
					$display("item %0d not expected: kind %0d addr %h value %h mask %h last %b",
						items_seen, got.kind, got.addr, got.value, got.mask, got.last);
				fail_count++;
			end else begin
				want = lcd_items_due.pop_front();
				if (got.kind !== want.kind || got.addr !== want.addr ||
						got.value !== want.value || got.mask !== want.mask ||
						got.last !== want.last) begin
					if (fail_count < 10)
						$display("item %0d kind/addr/value/mask/last: expected %0d %h %h %h %b, got %0d %h %h %h %b",
							items_seen,
							want.kind, want.addr, want.value, want.mask, want.last,
							got.kind, got.addr, got.value, got.mask, got.last);
					fail_count++;
				end
			end
			items_seen++;
		end
	end

	// one text item; optional idle gap in front of it
	task automatic send_char(input logic [7:0] code, input logic fin);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		sent_chars++;
		predict_glyph_items(code, fin);
	endtask

	// stop sending, wait for everything owed, then let non-drawing items settle
	task automatic drain_glyph_items();
		s_tvalid <= 1'b0;
		while (lcd_items_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one register write; valid stays high for a following write
	task automatic write_cfg(input tlg_pkg::cfg_index_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tlg_pkg::CFG_ORIGIN_X: begin
				org_x   = int'(val[7:0]);
				cur_col = org_x;
			end
			tlg_pkg::CFG_ORIGIN_Y: begin
				org_y   = int'(val[7:0]);
				cur_row = org_y;
			end
			default: ;  // colours only matter to the pixel serializer
		endcase
	endtask

	// all four registers, written only once the block has gone quiet
	task automatic load_settings(input logic [7:0] ox, input logic [7:0] oy,
			input logic [15:0] fg, input logic [15:0] bg);
		drain_glyph_items();
		write_cfg(tlg_pkg::CFG_ORIGIN_X, {8'h00, ox});
		write_cfg(tlg_pkg::CFG_ORIGIN_Y, {8'h00, oy});
		write_cfg(tlg_pkg::CFG_FORE_COLOR, fg);
		write_cfg(tlg_pkg::CFG_BACK_COLOR, bg);
		cfg_valid <= 1'b0;
	endtask

	// mostly drawable text, some odd codes and newlines
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return 8'($urandom_range(65, 90));
		else if (r < 60)
			return 8'($urandom_range(48, 57));
		else if (r < 68)
			return tlg_pkg::CODE_FIRST;
		else if (r < 76)
			return 8'($urandom_range(tlg_pkg::CODE_FIRST, tlg_pkg::CODE_LAST));
		else if (r < 83)
			return tlg_pkg::CODE_NEWLINE;
		return 8'($urandom_range(255));
	endfunction

	task automatic test_directed();
		send_idle_pct  = 18;
		recv_stall_pct = 18;
		load_settings(8'd0, 8'd0, 16'hFFFF, 16'h0000);
		// space, first and last digit, first and last letter
		send_char(tlg_pkg::CODE_FIRST, 1'b0);
		send_char("0", 1'b0);
		send_char("9", 1'b0);
		send_char("A", 1'b0);
		send_char(tlg_pkg::CODE_LAST, 1'b0);
		// printable but not in the font: blank glyph
		send_char("!", 1'b0);
		// just outside the printable range and the byte extremes: advance only
		send_char(tlg_pkg::CODE_FIRST - 8'd1, 1'b0);
		send_char(tlg_pkg::CODE_LAST + 8'd1, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		// eleventh advance of the row, wraps at the right edge
		send_char("M", 1'b0);
		send_char(tlg_pkg::CODE_NEWLINE, 1'b0);
		send_char("N", 1'b1);
		// origin moved while a string is half done
		send_char("A", 1'b0);
		send_char("B", 1'b0);
		load_settings(8'd100, 8'd50, 16'h1234, 16'h4321);
		send_char("C", 1'b1);
		// bottom right origin: the first drawn character stops the string
		load_settings(8'd175, 8'd219, 16'h0000, 16'hFFFF);
		send_char("W", 1'b0);
		send_char("X", 1'b0);
		send_char(tlg_pkg::CODE_NEWLINE, 1'b0);
		send_char("Y", 1'b1);
		send_char("Z", 1'b1);
	endtask

	// newlines skip the bottom check, so the row runs past the screen bottom
	task automatic test_row_saturation();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		load_settings(8'd0, 8'd200, 16'h0000, 16'hFFFF);
		for (int n = 0; n < 10; n++)
			send_char(tlg_pkg::CODE_NEWLINE, 1'b0);
		// drawn below the bottom, then the string stops
		send_char("8", 1'b0);
		send_char("Q", 1'b1);
	endtask

	// strings of random text; a few end early to break the pattern
	task automatic test_random_text(input int idle_pct, input int stall_pct,
			input logic [7:0] ox, input logic [7:0] oy);
		int start;
		int len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		load_settings(ox, oy, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
		start = sent_chars;
		while (sent_chars - start < PHASE_CHARS) begin
			len = $urandom_range(1, 24);
			for (int k = 1; k <= len; k++)
				send_char(pick_char(), (k == len) || ($urandom_range(99) < 3));
		end
	endtask

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_row_saturation();
		// no idling, then sender idle, receiver stalls, both
		test_random_text(0, 0, 8'd0, 8'd0);
		test_random_text(64, 0, 8'($urandom_range(175)), 8'($urandom_range(100)));
		test_random_text(0, 64, 8'd175, 8'd0);
		test_random_text(18, 18, 8'($urandom_range(175)), 8'($urandom_range(219)));
		drain_glyph_items();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
